// ===== design/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler package
// Shared constants, request and result types and helper functions.
// ----------------------------------------------------------------------------
package cmr_pkg;

	// Store geometry.
	localparam int NODES          = 16;
	localparam int FRAMES_PER_MSG = 8;
	localparam int FIRST_PAYLOAD  = 6;
	localparam int NEXT_PAYLOAD   = 7;
	localparam int END_CODE       = 0;
	localparam int FIRST_CODE     = 1;
	localparam int MAX_LEN        = FIRST_PAYLOAD + (FRAMES_PER_MSG - 1) * NEXT_PAYLOAD;

	// Derived widths.
	localparam int NODE_W  = $clog2(NODES);
	localparam int FRAME_W = $clog2(FRAMES_PER_MSG);
	localparam int HELD_W  = $clog2(FRAMES_PER_MSG + 1);
	localparam int COUNT_W = $clog2(MAX_LEN);
	localparam int SEQ_W   = 3;
	localparam int ADDR_W  = NODE_W + FRAME_W;

	// Byte positions within a frame word.
	localparam logic [2:0] FIRST_START = 3'(8 - FIRST_PAYLOAD);
	localparam logic [2:0] NEXT_START  = 3'(8 - NEXT_PAYLOAD);
	localparam logic [2:0] BYTE_LAST   = 3'd7;

	localparam logic [7:0] CRC_POLY = 8'h07;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_CRC    = 2'd1,
		ST_COUNT  = 2'd2,
		ST_LENGTH = 2'd3
	} status_t;

	// One received frame.
	typedef struct packed {
		logic [10:0] frame_id;
		logic [63:0] frame_data;
	} frame_t;

	// One result item.
	typedef struct packed {
		logic [3:0] node_id;
		logic [3:0] msg_class;
		logic [3:0] msg_dest;
		logic [7:0] msg_byte;
		logic       last;
		status_t    status;
	} result_t;

	// One byte of CRC-8, MSB first.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		c = crc ^ din;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// Largest message length that fits in n frames; zero for no frames.
	function automatic logic [7:0] frame_limit(input logic [HELD_W-1:0] n);
		logic [7:0] lim;
		lim = '0;
		if (n != '0) begin
			lim = 8'(FIRST_PAYLOAD + NEXT_PAYLOAD * (int'(n) - 1));
		end
		return lim;
	endfunction

endpackage

// ===== design/cmr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Synchronous write, registered read with a read enable.
// ----------------------------------------------------------------------------
module cmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/can_multiframe_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler
// Stores in-order frames per node and streams out the joined message.
// ----------------------------------------------------------------------------
// A frame that is not an end frame is taken and busy stays low.
// An end frame holds busy for a header read and a check step, then with checking on a CRC
// pass over every byte and a rewind fetch, then the output pass; each pass walks the bytes
// in order with a fetch for each further frame, and a failed check ends in an error result.
// Each result is registered, leaving in the cycle after its step, and cannot be stalled.
// Reset clears all frame counts and sets CRC checking on; RAM is not cleared.
module can_multiframe_reassembler_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmr_pkg::frame_t  frame,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,
	output logic             result_valid,
	output cmr_pkg::result_t result
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HEAD  = 6'b000010,
		S_EVAL  = 6'b000100,
		S_FETCH = 6'b001000,
		S_WALK  = 6'b010000,
		S_FAIL  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [cmr_pkg::HELD_W-1:0]  held_q [cmr_pkg::NODES];
	logic                        crc_en_q;
	logic                        result_valid_q;
	cmr_pkg::result_t            result_q;

	logic [cmr_pkg::NODE_W-1:0]  node_q;
	logic [cmr_pkg::HELD_W-1:0]  n_q;
	logic [cmr_pkg::FRAME_W-1:0] fk_q;
	logic [2:0]                  b_q;
	logic [cmr_pkg::COUNT_W-1:0] count_q;
	logic [cmr_pkg::COUNT_W-1:0] tgt_q;
	logic [7:0]                  crc_q;
	logic                        send_q;
	cmr_pkg::status_t            err_q;

	// Request decode.
	logic                        accept;
	logic [cmr_pkg::NODE_W-1:0]  node_idx;
	logic                        node_ok;
	logic [cmr_pkg::SEQ_W-1:0]   seq;
	logic                        is_first;
	logic                        is_end;
	logic [cmr_pkg::HELD_W-1:0]  held_eff;
	logic                        in_order;
	logic                        store;

	// RAM ports.
	logic                        frame_re;
	logic [63:0]                 frame_rdata;
	logic                        fid_we;
	logic [10:0]                 fid_rdata;

	// Assembly.
	logic [7:0]                  len;
	logic                        count_ok;
	cmr_pkg::status_t            eval_status;
	logic [7:0]                  wbyte;
	logic                        at_tgt;
	logic                        emit;
	logic [7:0]                  emit_byte;
	logic                        emit_last;
	cmr_pkg::status_t            emit_status;

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Decide whether an incoming frame is stored.
	always_comb begin
		accept   = start && !busy;
		node_idx = frame.frame_data[cmr_pkg::NODE_W-1:0];
		node_ok  = ({1'b0, frame.frame_data[7:0]} < 9'(cmr_pkg::NODES));
		seq      = frame.frame_id[cmr_pkg::SEQ_W-1:0];
		is_first = (seq == cmr_pkg::SEQ_W'(cmr_pkg::FIRST_CODE));
		is_end   = (seq == cmr_pkg::SEQ_W'(cmr_pkg::END_CODE));
		held_eff = is_first ? '0 : held_q[node_idx];
		in_order = (cmr_pkg::HELD_W'(seq) == held_eff + cmr_pkg::HELD_W'(1));
		store    = accept && node_ok
			&& (held_eff < cmr_pkg::HELD_W'(cmr_pkg::FRAMES_PER_MSG))
			&& (is_end || in_order);
		fid_we   = store && (held_eff == '0);
	end

	assign frame_re = (state_q == S_HEAD) || (state_q == S_FETCH);

	cmr_ram #(
		.WIDTH(64),
		.DEPTH(cmr_pkg::NODES * cmr_pkg::FRAMES_PER_MSG)
	) u_frame_ram (
		.clk  (clk),
		.we   (store),
		.waddr({node_idx, held_eff[cmr_pkg::FRAME_W-1:0]}),
		.wdata(frame.frame_data),
		.re   (frame_re),
		.raddr({node_q, fk_q}),
		.rdata(frame_rdata)
	);

	cmr_ram #(
		.WIDTH(11),
		.DEPTH(cmr_pkg::NODES)
	) u_fid_ram (
		.clk  (clk),
		.we   (fid_we),
		.waddr(node_idx),
		.wdata(frame.frame_id),
		.re   (state_q == S_HEAD),
		.raddr(node_q),
		.rdata(fid_rdata)
	);

	// Header checks on the first stored frame.
	always_comb begin
		len      = frame_rdata[15:8];
		count_ok = (len <= cmr_pkg::frame_limit(n_q))
			&& ((n_q == cmr_pkg::HELD_W'(1))
			|| (len > cmr_pkg::frame_limit(n_q - cmr_pkg::HELD_W'(1))));
		if (len > 8'(cmr_pkg::MAX_LEN)) begin
			eval_status = cmr_pkg::ST_LENGTH;
		end else if (!count_ok) begin
			eval_status = cmr_pkg::ST_COUNT;
		end else begin
			eval_status = cmr_pkg::ST_CRC;
		end
		wbyte  = frame_rdata[8*b_q +: 8];
		at_tgt = (count_q == tgt_q);
	end

	// Sequencer next state and result generation.
	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		emit_byte   = '0;
		emit_last   = 1'b0;
		emit_status = cmr_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (store && is_end) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if ((len > 8'(cmr_pkg::MAX_LEN)) || !count_ok || (crc_en_q && len == '0)) begin
					state_d = S_FAIL;
				end else if (len == '0) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_FETCH: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				if (!send_q) begin
					if (at_tgt) begin
						if (crc_q != wbyte) begin
							state_d = S_FAIL;
						end else if (tgt_q == '0) begin
							state_d = S_IDLE;
						end else begin
							state_d = S_FETCH;
						end
					end else if (b_q == cmr_pkg::BYTE_LAST) begin
						state_d = S_FETCH;
					end
				end else begin
					emit      = 1'b1;
					emit_byte = wbyte;
					emit_last = at_tgt;
					if (at_tgt) begin
						state_d = S_IDLE;
					end else if (b_q == cmr_pkg::BYTE_LAST) begin
						state_d = S_FETCH;
					end
				end
			end
			S_FAIL: begin
				emit        = 1'b1;
				emit_last   = 1'b1;
				emit_status = err_q;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			crc_en_q       <= 1'b1;
			result_valid_q <= 1'b0;
			for (int i = 0; i < cmr_pkg::NODES; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit;
			if (cfg_valid && cfg_ready) begin
				crc_en_q <= cfg_data;
			end
			if (store) begin
				held_q[node_idx] <= is_end ? '0 : held_eff + cmr_pkg::HELD_W'(1);
			end
		end
	end

	// Assembly datapath: byte walker over the stored frames.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (store && is_end) begin
					node_q <= node_idx;
					n_q    <= held_eff + cmr_pkg::HELD_W'(1);
					fk_q   <= '0;
				end
			end
			S_EVAL: begin
				err_q   <= eval_status;
				b_q     <= cmr_pkg::FIRST_START;
				fk_q    <= '0;
				count_q <= '0;
				crc_q   <= '0;
				tgt_q   <= cmr_pkg::COUNT_W'(len - 8'd1);
				send_q  <= !crc_en_q;
			end
			S_WALK: begin
				if (!send_q && at_tgt) begin
					// CRC good so far: rewind to stream the bytes before it.
					err_q   <= cmr_pkg::ST_CRC;
					send_q  <= 1'b1;
					tgt_q   <= tgt_q - cmr_pkg::COUNT_W'(1);
					count_q <= '0;
					fk_q    <= '0;
					b_q     <= cmr_pkg::FIRST_START;
				end else begin
					crc_q   <= cmr_pkg::crc8_step(crc_q, wbyte);
					count_q <= count_q + cmr_pkg::COUNT_W'(1);
					if (b_q == cmr_pkg::BYTE_LAST) begin
						fk_q <= fk_q + cmr_pkg::FRAME_W'(1);
						b_q  <= cmr_pkg::NEXT_START;
					end else begin
						b_q <= b_q + 3'd1;
					end
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			result_q.node_id   <= 4'(node_q);
			result_q.msg_class <= fid_rdata[10:7];
			result_q.msg_dest  <= fid_rdata[6:3];
			result_q.msg_byte  <= emit_byte;
			result_q.last      <= emit_last;
			result_q.status    <= emit_status;
		end
	end

	// An error result always closes its message.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.status != cmr_pkg::ST_OK) |-> result_q.last)
		else $error("error result without last");

	// After the final result the sequencer is back at rest.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.last |-> state_q == S_IDLE)
		else $error("sequencer busy after final result");

	// Results only come from the output pass or the error step.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(state_q == S_WALK || state_q == S_FAIL))
		else $error("result outside output pass");

	// The byte walker never runs past its target.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> count_q <= tgt_q)
		else $error("byte count beyond target");

	// No frame is stored while a message is being assembled.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !store)
		else $error("frame stored during assembly");

endmodule

// ===== bench/can_multiframe_reassembler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler testbench
// Drives CAN frames through the start/busy request port and checks every
// strobed result against a cycle-free model of the per-node frame stores,
// the length and frame-count checks and the trailing CRC-8. A short table of
// directed frames comes first, then random messages with random content,
// broken messages and stray frames, under several idling and CRC settings.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cmr_pkg::*;

	localparam int SETTLE_CYCLES  = 140;
	localparam int END_CYCLES     = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 110;

	typedef logic [7:0] msg_bytes_t [MAX_LEN];

	// Kinds of row in the directed table.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_FAULT,
		ROW_CRC_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [10:0] id;
		logic [63:0] data;
		status_t     st;
	} stim_row_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    start     = 1'b0;
	logic    busy;
	frame_t  frame_in  = '0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data  = 1'b0;
	logic    result_valid;
	result_t result_out;

	// Model state: frames held per node, the stored frames and the head identifier.
	int          held_cnt   [NODES];
	logic [63:0] frame_copy [NODES][FRAMES_PER_MSG];
	logic [10:0] head_id    [NODES];
	bit          crc_on = 1'b1;

	result_t predicted[$];
	result_t awaited[$];
	result_t want;
	int      mismatches   = 0;
	int      frames_sent  = 0;
	int      idle_pct     = 0;
	int      quiet_cycles = 0;

	can_multiframe_reassembler_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.frame        (frame_in),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result_out)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CRC-8, polynomial 0x07, zero start value, most significant bit first.
	function automatic logic [7:0] crc8_of(input msg_bytes_t bytes_in, input int n);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < n; i++) begin
			r = r ^ bytes_in[i];
			repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	// Updates the node stores for one accepted frame and leaves the results it
	// causes in the predicted queue.
	function automatic void reassemble(input frame_t f);
		msg_bytes_t  mb;
		result_t     r;
		status_t     st;
		logic [10:0] fid;
		int          node, seq, held, len, need, outlen, cnt, first;
		predicted.delete();
		node = int'(f.frame_data[7:0]);
		if (node >= NODES)
			return;
		seq  = int'(f.frame_id[2:0]);
		held = (seq == FIRST_CODE) ? 0 : held_cnt[node];
		if (held >= FRAMES_PER_MSG)
			return;
		if (seq != END_CODE && seq != held + 1) begin
			held_cnt[node] = held;
			return;
		end
		frame_copy[node][held] = f.frame_data;
		if (held == 0)
			head_id[node] = f.frame_id;
		held++;
		if (seq != END_CODE) begin
			held_cnt[node] = held;
			return;
		end
		held_cnt[node] = 0;

		// Join the payloads: bytes 2..7 of the first frame, 1..7 of the rest.
		fid = head_id[node];
		len = int'(frame_copy[node][0][15:8]);
		cnt = 0;
		for (int k = 0; k < held; k++) begin
			first = (k == 0) ? 8 - FIRST_PAYLOAD : 8 - NEXT_PAYLOAD;
			for (int b = first; b < 8 && cnt < MAX_LEN; b++) begin
				mb[cnt] = frame_copy[node][k][8*b +: 8];
				cnt++;
			end
		end

		st     = ST_OK;
		outlen = 0;
		if (len > MAX_LEN) begin
			st = ST_LENGTH;
		end else begin
			need = (len <= FIRST_PAYLOAD) ? 1 :
				1 + (len - FIRST_PAYLOAD + NEXT_PAYLOAD - 1) / NEXT_PAYLOAD;
			if (need != held)
				st = ST_COUNT;
			else if (!crc_on)
				outlen = len;
			else if (len == 0 || crc8_of(mb, len - 1) != mb[len - 1])
				st = ST_CRC;
			else
				outlen = len - 1;
		end

		r.node_id   = 4'(node);
		r.msg_class = fid[10:7];
		r.msg_dest  = fid[6:3];
		if (st != ST_OK) begin
			r.msg_byte = 8'h00;
			r.last     = 1'b1;
			r.status   = st;
			predicted.push_back(r);
		end else begin
			for (int k = 0; k < outlen; k++) begin
				r.msg_byte = mb[k];
				r.last     = (k == outlen - 1);
				r.status   = ST_OK;
				predicted.push_back(r);
			end
		end
	endfunction

	function automatic stim_row_t stim_row(input row_kind_t kind, input logic [10:0] id,
			input logic [63:0] data, input status_t st);
		stim_row_t s;
		s.kind = kind;
		s.id   = id;
		s.data = data;
		s.st   = st;
		return s;
	endfunction

	// Number of idle cycles after a request, drawn one cycle at a time.
	function automatic int idle_gap();
		int n;
		n = 0;
		while (n < 40 && $urandom_range(99) < idle_pct)
			n++;
		return n;
	endfunction

	// Presents one frame, waits until it is taken and updates the model.
	task automatic send_frame(input logic [10:0] id, input logic [63:0] data,
			input bit use_model);
		frame_t f;
		f.frame_id   = id;
		f.frame_data = data;
		start    <= 1'b1;
		frame_in <= f;
		do @(posedge clk); while (busy);
		frames_sent++;
		reassemble(f);
		if (use_model)
			foreach (predicted[i]) awaited.push_back(predicted[i]);
	endtask

	task automatic hold_off(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
	endtask

	// The register is only written once the block has gone quiet.
	task automatic set_crc_check(input bit value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		crc_on = value;
	endtask

	// A stray frame: fully random, or random with a node in range.
	task automatic send_noise();
		logic [63:0] d;
		d = {$urandom, $urandom};
		if ($urandom_range(1) == 1)
			d[7:0] = 8'($urandom_range(NODES - 1));
		send_frame(11'($urandom), d, 1'b1);
		hold_off(idle_gap());
	endtask

	// One message split into frames; a quarter of them carry a flaw: a random
	// length, a corrupted CRC byte or a missing frame.
	task automatic send_message();
		msg_bytes_t mb;
		logic [63:0] w;
		logic [3:0]  mtype, mtarget;
		logic [2:0]  seq;
		int          node, nf, len, flaw, drop;
		flaw = 0;
		drop = -1;
		node = $urandom_range(NODES - 1);
		nf   = $urandom_range(FRAMES_PER_MSG, 1);
		if (nf == 1)
			len = $urandom_range(FIRST_PAYLOAD);
		else
			len = $urandom_range(FIRST_PAYLOAD + NEXT_PAYLOAD * (nf - 1),
				FIRST_PAYLOAD + NEXT_PAYLOAD * (nf - 2) + 1);
		if ($urandom_range(99) < 25)
			flaw = $urandom_range(3, 1);
		if (flaw == 1)
			len = $urandom_range(255);
		if (flaw == 3 && nf > 1)
			drop = $urandom_range(nf - 1, 1);
		foreach (mb[i]) mb[i] = 8'($urandom);
		if (len > 0 && len <= MAX_LEN) begin
			mb[len - 1] = crc8_of(mb, len - 1);
			if (flaw == 2)
				mb[len - 1] = mb[len - 1] ^ 8'($urandom_range(255, 1));
		end
		mtype   = 4'($urandom);
		mtarget = 4'($urandom);

		for (int k = 0; k < nf; k++) begin
			if (k != drop) begin
				w = {$urandom, $urandom};
				w[7:0] = 8'(node);
				if (k == 0) begin
					w[15:8] = 8'(len);
					for (int b = 2; b < 8; b++)
						w[8*b +: 8] = mb[b - 2];
				end else begin
					for (int b = 1; b < 8; b++)
						w[8*b +: 8] = mb[FIRST_PAYLOAD + NEXT_PAYLOAD * (k - 1) + b - 1];
				end
				seq = (k == nf - 1) ? 3'(END_CODE) : 3'(k + 1);
				if ($urandom_range(9) == 0)
					send_noise();
				send_frame({mtype, mtarget, seq}, w, 1'b1);
				hold_off(idle_gap());
			end
		end
	endtask

	// Result checker: each strobed result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none,", $time);
				$display("%0t:   got node %0d class %0d dest %0d byte %02h last %0b status %0d",
					$time, result_out.node_id, result_out.msg_class, result_out.msg_dest,
					result_out.msg_byte, result_out.last, result_out.status);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (result_out !== want) begin
					$display("%0t: mismatch, expected node %0d class %0d dest %0d byte %02h last %0b status %0d",
						$time, want.node_id, want.msg_class, want.msg_dest,
						want.msg_byte, want.last, want.status);
					$display("%0t:           got node %0d class %0d dest %0d byte %02h last %0b status %0d",
						$time, result_out.node_id, result_out.msg_class, result_out.msg_dest,
						result_out.msg_byte, result_out.last, result_out.status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: ends the run after too long without any handshake.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("can_multiframe_reassembler_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		stim_row_t directed[$];
		result_t   fault;
		int        idle_mix [4];
		bit        crc_mix  [4];
		idle_mix = '{0, 61, 24, 0};
		crc_mix  = '{1'b0, 1'b1, 1'b0, 1'b1};

		// Directed frames. Fault rows are single end frames on an empty store,
		// so the expected error result is read straight off the row.
		directed.push_back(stim_row(ROW_FAULT, {4'h0, 4'h0, 3'd0}, 64'h0, ST_CRC));
		directed.push_back(stim_row(ROW_SILENT, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK));
		directed.push_back(stim_row(ROW_SILENT, {4'h3, 4'h5, 3'd1}, 64'h0000_0000_0000_0010, ST_OK));
		directed.push_back(stim_row(ROW_FAULT, 11'h7F8, 64'hFFFF_FFFF_FFFF_FF0F, ST_LENGTH));
		directed.push_back(stim_row(ROW_FAULT, {4'h2, 4'h9, 3'd0}, 64'h0000_0000_0000_3802, ST_LENGTH));
		directed.push_back(stim_row(ROW_FAULT, {4'h1, 4'h2, 3'd0}, 64'h0000_0000_0000_0704, ST_COUNT));
		directed.push_back(stim_row(ROW_SILENT, {4'h3, 4'h3, 3'd3}, 64'h0000_0000_0000_0006, ST_OK));
		directed.push_back(stim_row(ROW_SILENT, 11'h7FF, 64'hFFFF_FFFF_FFFF_FF01, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h6, 4'hA, 3'd0}, 64'h0000_0000_0701_0205, ST_OK));
		directed.push_back(stim_row(ROW_SILENT, {4'h6, 4'hA, 3'd0}, 64'h0000_0000_0000_0105, ST_OK));
		directed.push_back(stim_row(ROW_CRC_CFG, 11'h000, 64'h0, ST_OK));
		directed.push_back(stim_row(ROW_SILENT, {4'h5, 4'h1, 3'd0}, 64'h0000_0000_0000_0009, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h4, 4'hC, 3'd1}, 64'h1122_3344_5566_0D07, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h4, 4'hC, 3'd0}, 64'h7788_99AA_BBCC_DD07, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd1}, 64'hF0E1_D2C3_B4A5_3708, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd2}, 64'h0011_2233_4455_6608, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd3}, 64'h8899_AABB_CCDD_EE08, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd4}, 64'hFF00_FF00_FF00_FF08, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd5}, 64'h5A5A_5A5A_5A5A_5A08, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd6}, 64'hC3C3_C3C3_C3C3_C308, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd7}, 64'h0123_4567_89AB_CD08, ST_OK));
		directed.push_back(stim_row(ROW_PREDICT, {4'h9, 4'h3, 3'd0}, 64'hFEDC_BA98_7654_3208, ST_OK));
		directed.push_back(stim_row(ROW_CRC_CFG, 11'h000, 64'h1, ST_OK));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_CRC_CFG: begin
					set_crc_check(directed[i].data[0]);
				end
				default: begin
					send_frame(directed[i].id, directed[i].data, directed[i].kind == ROW_PREDICT);
					if (directed[i].kind == ROW_FAULT) begin
						fault.node_id   = directed[i].data[3:0];
						fault.msg_class = directed[i].id[10:7];
						fault.msg_dest  = directed[i].id[6:3];
						fault.msg_byte  = 8'h00;
						fault.last      = 1'b1;
						fault.status    = directed[i].st;
						awaited.push_back(fault);
					end
					hold_off(idle_gap());
				end
			endcase
		end

		// Random phases, each with its own idling mix and CRC setting.
		for (int p = 0; p < 4; p++) begin
			set_crc_check(crc_mix[p]);
			idle_pct = idle_mix[p];
			while (frames_sent < 25 + PHASE_ITEMS * (p + 1)) begin
				if ($urandom_range(99) < 12)
					send_noise();
				else
					send_message();
				// Now and then the sender waits for every outstanding result.
				if ($urandom_range(29) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited.size() == 0)
			$display("can_multiframe_reassembler_unit_tb: done, clean");
		else
			$display("can_multiframe_reassembler_unit_tb: done, errors");
		$finish;
	end

endmodule

// ===== can_multiframe_reassembler_unit.f =====
design/cmr_pkg.sv
design/cmr_ram.sv
design/can_multiframe_reassembler_unit.sv
bench/can_multiframe_reassembler_unit_tb.sv
